// ===== hw/rtl/rtim_pkg.sv =====
// ----------------------------------------------------------------------------
// rtim_pkg
// Types and constants shared by the rapid trigger input mapper modules.
// ----------------------------------------------------------------------------
package rtim_pkg;

    localparam int SLOT_W      = 6;
    localparam int SAMPLE_W    = 12;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 6;
    localparam int TKIND_W     = 3;
    localparam int MODE_W      = 2;
    localparam int STATIC_W    = 13;
    localparam int THR_W       = 12;
    localparam int OP_W        = 2;
    localparam int CONTRIB_W   = 16;
    localparam int SLOT_CODES  = 2 ** SLOT_W;

    // joystick halves are doubled, so a level needs one bit more than a sample
    localparam int LVL_W       = SAMPLE_W + 1;
    // largest tracking value is a doubled sample plus a full threshold
    localparam int TRACK_W     = LVL_W + 1;

    localparam logic [LVL_W-1:0] FULL_LEVEL = LVL_W'(12'hFFF);

    // input kinds
    localparam logic [KIND_W-1:0] IK_UNUSED  = 2'd0;
    localparam logic [KIND_W-1:0] IK_DIGITAL = 2'd1;
    localparam logic [KIND_W-1:0] IK_HOVER   = 2'd2;
    localparam logic [KIND_W-1:0] IK_JOY     = 2'd3;

    // target kinds
    localparam logic [TKIND_W-1:0] TK_DIGITAL = 3'd0;
    localparam logic [TKIND_W-1:0] TK_DPAD    = 3'd1;
    localparam logic [TKIND_W-1:0] TK_HOVER   = 3'd2;
    localparam logic [TKIND_W-1:0] TK_JOY     = 3'd3;

    // modes
    localparam logic [MODE_W-1:0] MODE_RAPID  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THRESH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PASS_B = 2'd3;

    // merge operations
    localparam logic [OP_W-1:0] MERGE_NONE  = 2'd0;
    localparam logic [OP_W-1:0] MERGE_OR    = 2'd1;
    localparam logic [OP_W-1:0] MERGE_MAX   = 2'd2;
    localparam logic [OP_W-1:0] MERGE_WRITE = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [SAMPLE_W-1:0] sample;
        logic [KIND_W-1:0]   input_kind;
        logic [CODE_W-1:0]   mapped_code;
        logic [TKIND_W-1:0]  target_kind;
        logic [MODE_W-1:0]   mode;
        logic [STATIC_W-1:0] static_level;
        logic [THR_W-1:0]    threshold;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]    target_code;
        logic [OP_W-1:0]      merge_op;
        logic [CONTRIB_W-1:0] contribution;
    } t_out_item;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               press;
    } t_rapid_state;

endpackage

// ===== hw/rtl/rtim_in_if.sv =====
// ----------------------------------------------------------------------------
// rtim_in_if
// Input sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtim_in_if;
    import rtim_pkg::*;

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
    logic [KIND_W-1:0]   input_kind;
    logic [CODE_W-1:0]   mapped_code;
    logic [TKIND_W-1:0]  target_kind;
    logic [MODE_W-1:0]   mode;
    logic [STATIC_W-1:0] static_level;
    logic [THR_W-1:0]    threshold;

    modport source (
        output valid, slot, sample, input_kind, mapped_code, target_kind, mode,
               static_level, threshold,
        input  ready
    );

    modport sink (
        input  valid, slot, sample, input_kind, mapped_code, target_kind, mode,
               static_level, threshold,
        output ready
    );
endinterface

// ===== hw/rtl/rtim_out_if.sv =====
// ----------------------------------------------------------------------------
// rtim_out_if
// Result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtim_out_if;
    import rtim_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CODE_W-1:0]    target_code;
    logic [OP_W-1:0]      merge_op;
    logic [CONTRIB_W-1:0] contribution;

    modport source (
        output valid, target_code, merge_op, contribution,
        input  ready
    );

    modport sink (
        input  valid, target_code, merge_op, contribution,
        output ready
    );
endinterface

// ===== hw/rtl/rtim_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rtim_cfg_if
// Configuration write channel for the remap enable register.
// ----------------------------------------------------------------------------
interface rtim_cfg_if;
    logic valid;
    logic ready;
    logic remap_enable;

    modport source (
        output valid, remap_enable,
        input  ready
    );

    modport sink (
        input  valid, remap_enable,
        output ready
    );
endinterface

// ===== hw/rtl/rtim_rapid_state.sv =====
// ----------------------------------------------------------------------------
// rtim_rapid_state
// Per-slot rapid trigger state memory with valid bits and write forwarding.
// ----------------------------------------------------------------------------
module rtim_rapid_state #(
    parameter int SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [rtim_pkg::SLOT_W-1:0]     i_rd_slot,
    input  logic                            i_wr_en,
    input  logic [rtim_pkg::SLOT_W-1:0]     i_wr_slot,
    input  rtim_pkg::t_rapid_state          i_wr_data,
    output rtim_pkg::t_rapid_state          o_rd_data
);
    import rtim_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [IDX_W-1:0] w_mod [SLOT_CODES];
    logic [IDX_W-1:0] w_rd_idx;
    logic [IDX_W-1:0] w_wr_idx;
    logic             w_fwd;

    t_rapid_state     r_mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    logic [SLOTS-1:0] n_vld;
    t_rapid_state     r_mem_q;
    t_rapid_state     r_fwd_data;
    logic             r_sel_fwd;
    logic             r_sel_vld;

    // slot codes beyond the depth wrap around
    for (genvar g = 0; g < SLOT_CODES; g++) begin : g_mod
        assign w_mod[g] = IDX_W'(g % SLOTS);
    end

    assign w_rd_idx = w_mod[i_rd_slot];
    assign w_wr_idx = w_mod[i_wr_slot];
    assign w_fwd    = i_wr_en && (w_wr_idx == w_rd_idx);

    always_comb begin
        n_vld = r_vld;
        if (i_wr_en) begin
            n_vld[w_wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[w_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mem_q    <= r_mem[w_rd_idx];
            r_fwd_data <= i_wr_data;
            r_sel_fwd  <= w_fwd;
            r_sel_vld  <= r_vld[w_rd_idx];
        end
    end

    // an entry never written reads as the reset state
    assign o_rd_data = r_sel_fwd ? r_fwd_data :
                       (r_sel_vld ? r_mem_q : '0);

    a_fwd_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && w_fwd) |=> (o_rd_data == $past(i_wr_data)))
        else $error("forwarded state does not match the write");

    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && !w_fwd && !r_vld[w_rd_idx]) |=> (o_rd_data == '0))
        else $error("unwritten entry does not read as reset state");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("valid bits not cleared by reset");

endmodule

// ===== hw/rtl/rtim_map.sv =====
// ----------------------------------------------------------------------------
// rtim_map
// Routing, rapid trigger update and contribution build for one sample.
// ----------------------------------------------------------------------------
module rtim_map #(
    parameter int PRESS_BIT = 15
) (
    input  rtim_pkg::t_in_item      i_item,
    input  logic                    i_remap,
    input  rtim_pkg::t_rapid_state  i_state,
    output rtim_pkg::t_out_item     o_res,
    output logic                    o_wr_en,
    output rtim_pkg::t_rapid_state  o_state
);
    import rtim_pkg::*;

    localparam logic [CONTRIB_W-1:0] PRESS_FLAG = CONTRIB_W'(1) << PRESS_BIT;

    logic                 w_joy;
    logic                 w_smp_nz;
    logic                 w_pass;
    logic [LVL_W-1:0]     w_lvl;
    logic [LVL_W-1:0]     w_thr;
    logic [LVL_W-1:0]     w_peak;
    logic [TRACK_W:0]     w_low_sum;
    logic                 w_ge;
    logic                 w_lt;
    logic                 w_rapid_p;
    logic                 w_thr_p;
    logic                 w_dig_p;
    logic                 w_ana_p;
    logic [LVL_W-1:0]     w_dpad_v;
    logic [LVL_W-1:0]     w_dpad_half;
    logic [LVL_W-1:0]     w_ana_v;
    logic [OP_W-1:0]      w_op;
    logic [CONTRIB_W-1:0] w_c;

    assign w_joy    = (i_item.input_kind == IK_JOY);
    assign w_smp_nz = (i_item.sample != '0);
    assign w_pass   = (i_item.mode == MODE_PASS) || (i_item.mode == MODE_PASS_B);
    assign w_lvl    = w_joy ? {i_item.sample, 1'b0} : {1'b0, i_item.sample};
    assign w_thr    = LVL_W'(i_item.threshold);
    assign w_peak   = (w_lvl < w_thr) ? w_thr : w_lvl;

    // level below track minus width, without going negative
    assign w_low_sum = (TRACK_W+1)'(w_lvl) + (TRACK_W+1)'(w_thr);
    assign w_ge      = (TRACK_W'(w_lvl) >= i_state.track);
    assign w_lt      = (w_low_sum < (TRACK_W+1)'(i_state.track));

    always_comb begin
        o_state = i_state;
        if (w_ge) begin
            o_state.press = 1'b1;
            o_state.track = TRACK_W'(w_peak);
        end else if (w_lt) begin
            o_state.press = 1'b0;
            o_state.track = TRACK_W'(w_low_sum);
        end
    end

    assign w_rapid_p = o_state.press;
    assign w_thr_p   = (w_lvl >= w_thr);
    assign w_dig_p   = (i_item.mode == MODE_THRESH) ? w_thr_p : w_rapid_p;
    assign w_ana_p   = (i_item.mode == MODE_RAPID) ? w_rapid_p : w_thr_p;

    assign w_dpad_v    = w_pass ? w_lvl : (w_ana_p ? FULL_LEVEL : '0);
    assign w_dpad_half = w_dpad_v >> 1;
    assign w_ana_v     = w_pass ? w_lvl :
                         (w_ana_p ? LVL_W'(i_item.static_level) : '0);

    always_comb begin
        w_op    = MERGE_NONE;
        w_c     = '0;
        o_wr_en = 1'b0;
        case (i_item.input_kind)
            IK_DIGITAL: begin
                if (w_smp_nz) begin
                    case (i_item.target_kind)
                        TK_DIGITAL: begin
                            w_op = MERGE_OR;
                            w_c  = CONTRIB_W'(FULL_LEVEL) | PRESS_FLAG;
                        end
                        TK_DPAD: begin
                            w_op = MERGE_MAX;
                            w_c  = CONTRIB_W'(FULL_LEVEL) | PRESS_FLAG;
                        end
                        TK_HOVER, TK_JOY: begin
                            w_op = MERGE_MAX;
                            w_c  = CONTRIB_W'(i_item.static_level) | PRESS_FLAG;
                        end
                        default: begin
                            if (!i_remap) begin
                                w_op = MERGE_OR;
                                w_c  = CONTRIB_W'(FULL_LEVEL) | PRESS_FLAG;
                            end
                        end
                    endcase
                end
            end
            IK_HOVER, IK_JOY: begin
                case (i_item.target_kind)
                    TK_DIGITAL: begin
                        w_op    = MERGE_OR;
                        w_c     = CONTRIB_W'(w_lvl) | (w_dig_p ? PRESS_FLAG : '0);
                        o_wr_en = (i_item.mode != MODE_THRESH);
                    end
                    TK_DPAD: begin
                        w_op    = MERGE_WRITE;
                        o_wr_en = (i_item.mode == MODE_RAPID);
                        if (w_joy) begin
                            w_c = CONTRIB_W'(w_dpad_half) | (w_smp_nz ? PRESS_FLAG : '0);
                        end else begin
                            w_c = CONTRIB_W'(w_dpad_v) |
                                  ((w_dpad_v != '0) ? PRESS_FLAG : '0);
                        end
                    end
                    TK_HOVER, TK_JOY: begin
                        w_op    = MERGE_WRITE;
                        o_wr_en = (i_item.mode == MODE_RAPID);
                        w_c     = CONTRIB_W'(w_ana_v) |
                                  ((w_ana_v != '0) ? PRESS_FLAG : '0);
                    end
                    default: begin
                        if (!i_remap) begin
                            w_op = MERGE_OR;
                            w_c  = CONTRIB_W'(w_lvl) | (w_smp_nz ? PRESS_FLAG : '0);
                        end
                    end
                endcase
            end
            default: begin
                w_op = MERGE_NONE;
            end
        endcase
    end

    assign o_res.target_code  = i_remap ? i_item.mapped_code : i_item.slot;
    assign o_res.merge_op     = w_op;
    assign o_res.contribution = w_c;

endmodule

// ===== hw/rtl/rapid_trigger_input_mapper_core.sv =====
// pipeline: a transaction is registered in the stage register, then in the output register
// throughput: one transaction per cycle while the output is not stalled,
// with the rapid state read forwarded from the write of the previous transaction
// reset: synchronous active low; clears pipeline valids, all rapid state
// and sets remap_enable to 1
// ----------------------------------------------------------------------------
// rapid_trigger_input_mapper_core
// Maps controller input samples to output contributions with rapid trigger.
// ----------------------------------------------------------------------------
module rapid_trigger_input_mapper_core #(
    parameter int SLOTS     = 64,
    parameter int PRESS_BIT = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rtim_in_if.sink      i_in,
    rtim_out_if.source   o_out,
    rtim_cfg_if.sink     i_cfg
);
    import rtim_pkg::*;

    logic         r_remap;
    logic         r_s1_vld;
    logic         n_s1_vld;
    t_in_item     r_s1_item;
    logic         r_o_vld;
    logic         n_o_vld;
    t_out_item    r_o_item;

    logic         w_in_acc;
    logic         w_s1_adv;
    t_in_item     w_in_item;
    t_out_item    w_res;
    logic         w_map_wr;
    t_rapid_state w_rd_state;
    t_rapid_state w_new_state;

    assign w_in_item.slot         = i_in.slot;
    assign w_in_item.sample       = i_in.sample;
    assign w_in_item.input_kind   = i_in.input_kind;
    assign w_in_item.mapped_code  = i_in.mapped_code;
    assign w_in_item.target_kind  = i_in.target_kind;
    assign w_in_item.mode         = i_in.mode;
    assign w_in_item.static_level = i_in.static_level;
    assign w_in_item.threshold    = i_in.threshold;

    assign w_s1_adv  = r_s1_vld && (!r_o_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || w_s1_adv;
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_in_acc) begin
            n_s1_vld = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_vld = 1'b0;
        end
        n_o_vld = r_o_vld;
        if (w_s1_adv) begin
            n_o_vld = 1'b1;
        end else if (o_out.ready) begin
            n_o_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            r_remap  <= 1'b1;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= n_o_vld;
            if (i_cfg.valid) begin
                r_remap <= i_cfg.remap_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_item <= w_in_item;
        end
        if (w_s1_adv) begin
            r_o_item <= w_res;
        end
    end

    // state is written only when the transaction moves to the output register
    rtim_rapid_state #(
        .SLOTS (SLOTS)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_slot (i_in.slot),
        .i_wr_en   (w_s1_adv && w_map_wr),
        .i_wr_slot (r_s1_item.slot),
        .i_wr_data (w_new_state),
        .o_rd_data (w_rd_state)
    );

    rtim_map #(
        .PRESS_BIT (PRESS_BIT)
    ) u_map (
        .i_item  (r_s1_item),
        .i_remap (r_remap),
        .i_state (w_rd_state),
        .o_res   (w_res),
        .o_wr_en (w_map_wr),
        .o_state (w_new_state)
    );

    assign o_out.valid        = r_o_vld;
    assign o_out.target_code  = r_o_item.target_code;
    assign o_out.merge_op     = r_o_item.merge_op;
    assign o_out.contribution = r_o_item.contribution;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_o_vld)
        else $error("stage transaction lost on its way to the output");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_vld |-> i_in.ready)
        else $error("input stalled with an empty stage");

    a_max_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && (r_o_item.merge_op == MERGE_MAX)) |->
            r_o_item.contribution[PRESS_BIT])
        else $error("max merge without press flag");

endmodule
